// ===== rtl/dcs_pkg.sv =====
// Shared types and constants for the drive command supervisor.
// Holds field widths, register reset values, operation codes and the result record.
// No dependencies.
package dcs_pkg;

	localparam int MOTOR_COUNT = 4;
	localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	localparam int SPEED_W = 15;
	localparam int TIME_W  = 17;
	localparam int PERIOD_W = 16;
	localparam int COUNT_W = 15;
	localparam int REQ_W   = 16;
	localparam int ODO_W   = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [SPEED_W-1:0]  MAX_SPEED_RST  = SPEED_W'(500);
	localparam logic [TIME_W-1:0]   STOP_TO_RST    = TIME_W'(200);
	localparam logic [TIME_W-1:0]   DISC_TO_RST    = TIME_W'(60000);
	localparam logic [PERIOD_W-1:0] REPORT_PER_RST = PERIOD_W'(100);

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_COMMAND = 2'd1,
		ACT_EDGE    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CMD_CONNECT = 2'd0,
		CMD_RESET   = 2'd1,
		CMD_MOVE    = 2'd2,
		CMD_NOP     = 2'd3
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED   = 2'd0,
		REG_STOP_TO     = 2'd1,
		REG_DISC_TO     = 2'd2,
		REG_REPORT_PER  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                    connected;
		logic [SPEED_W-1:0]      left_setpoint;
		logic                    left_backward;
		logic [SPEED_W-1:0]      right_setpoint;
		logic                    right_backward;
		logic                    loop_reset;
		logic                    report_valid;
		logic signed [ODO_W-1:0] odometry_a;
		logic signed [ODO_W-1:0] odometry_b;
		logic signed [ODO_W-1:0] odometry_c;
		logic signed [ODO_W-1:0] odometry_d;
	} result_t;

endpackage

// ===== rtl/drive_command_supervisor_top.sv =====
// Drive command supervisor: link state, command timeouts, side setpoints and encoder counts.
// Depends on dcs_pkg for widths, codes and the result record.
//
// Results pass the result register, or the skid register in a stall, to res_valid.
// Throughput: one transaction per cycle while cmd_ready is high; all state is updated
// in the cycle of acceptance. A two-entry output (result register plus skid register)
// keeps cmd_ready high while one result waits. Reset (arst_n low) drops the link, clears
// timers, setpoints and tick counts, loads the register defaults and empties the output.
module drive_command_supervisor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dcs_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [1:0]                          action,
	input  logic [1:0]                          command_kind,
	input  logic signed [dcs_pkg::REQ_W-1:0]    left_request,
	input  logic signed [dcs_pkg::REQ_W-1:0]    right_request,
	input  logic [1:0]                          edge_motor,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                connected,
	output logic [dcs_pkg::SPEED_W-1:0]         left_setpoint,
	output logic                                left_backward,
	output logic [dcs_pkg::SPEED_W-1:0]         right_setpoint,
	output logic                                right_backward,
	output logic                                loop_reset,
	output logic                                report_valid,
	output logic signed [dcs_pkg::ODO_W-1:0]    odometry_a,
	output logic signed [dcs_pkg::ODO_W-1:0]    odometry_b,
	output logic signed [dcs_pkg::ODO_W-1:0]    odometry_c,
	output logic signed [dcs_pkg::ODO_W-1:0]    odometry_d
);
	import dcs_pkg::*;

	// Configuration registers.
	logic [SPEED_W-1:0]  max_speed_q;
	logic [TIME_W-1:0]   stop_to_q;
	logic [TIME_W-1:0]   disc_to_q;
	logic [PERIOD_W-1:0] report_per_q;

	// Supervisor state.
	logic               link_q;
	logic [TIME_W-1:0]  since_cmd_q;
	logic [TIME_W-1:0]  since_rep_q;
	logic [SPEED_W-1:0] speed_q [2];
	logic               rev_q [2];
	logic [COUNT_W-1:0] count_q [MOTOR_COUNT];

	// Output stage.
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	logic accept;
	action_t  act;
	command_t kind;

	logic               link_d;
	logic [TIME_W-1:0]  since_cmd_d;
	logic [TIME_W-1:0]  since_rep_d;
	logic [SPEED_W-1:0] speed_d [2];
	logic               rev_d [2];
	logic [COUNT_W-1:0] count_d [MOTOR_COUNT];

	logic [TIME_W-1:0]  cmd_inc;
	logic [TIME_W-1:0]  rep_inc;
	logic               do_move;
	logic               move_user;
	logic               report;
	logic               stopped;
	logic signed [REQ_W-1:0] req [2];
	logic [REQ_W-1:0]   mag [2];
	logic signed [ODO_W-1:0] odo [4];
	result_t            res;

	assign act       = action_t'(action);
	assign kind      = command_t'(command_kind);
	assign cmd_ready = ~skid_valid_q;
	assign accept    = cmd_valid & cmd_ready;

	assign cmd_inc = (since_cmd_q == TIME_MAX) ? since_cmd_q : since_cmd_q + TIME_W'(1);
	assign rep_inc = (since_rep_q == TIME_MAX) ? since_rep_q : since_rep_q + TIME_W'(1);

	always_comb begin
		link_d      = link_q;
		since_cmd_d = since_cmd_q;
		since_rep_d = since_rep_q;
		count_d     = count_q;
		do_move     = 1'b0;
		move_user   = 1'b0;
		report      = 1'b0;

		case (act)
			ACT_TICK: begin
				since_cmd_d = cmd_inc;
				since_rep_d = rep_inc;
				if (link_q) begin
					if (cmd_inc > disc_to_q) begin
						do_move = 1'b1;
						link_d  = 1'b0;
					end else begin
						if (cmd_inc > stop_to_q) begin
							do_move = 1'b1;
						end
						if (rep_inc > {1'b0, report_per_q}) begin
							report      = 1'b1;
							since_rep_d = '0;
							for (int i = 0; i < MOTOR_COUNT; i++) begin
								count_d[i] = '0;
							end
						end
					end
				end
			end
			ACT_COMMAND: begin
				if (link_q) begin
					since_cmd_d = '0;
					case (kind)
						CMD_CONNECT: do_move = 1'b1;
						CMD_RESET: begin
							do_move = 1'b1;
							link_d  = 1'b0;
						end
						CMD_MOVE: begin
							do_move   = 1'b1;
							move_user = 1'b1;
						end
						default: ;
					endcase
				end else if (kind == CMD_CONNECT) begin
					since_cmd_d = '0;
					link_d      = 1'b1;
					do_move     = 1'b1;
				end
			end
			ACT_EDGE: begin
				for (int i = 0; i < MOTOR_COUNT; i++) begin
					if ({1'b0, edge_motor} == 3'(i) && count_q[i] != COUNT_MAX) begin
						count_d[i] = count_q[i] + COUNT_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Move: the final setpoint of each side depends only on its own request; a reversal or
	// a zero request on either side only raises loop_reset and does not stop the other side.
	always_comb begin
		req[0] = move_user ? left_request  : '0;
		req[1] = move_user ? right_request : '0;
		stopped = 1'b0;
		for (int s = 0; s < 2; s++) begin
			speed_d[s] = speed_q[s];
			rev_d[s]   = rev_q[s];
			mag[s]     = req[s][REQ_W-1] ? (~req[s] + REQ_W'(1)) : req[s];
		end
		if (do_move) begin
			for (int s = 0; s < 2; s++) begin
				if (req[s][REQ_W-1] != rev_q[s] || req[s] == '0) begin
					stopped = 1'b1;
				end
				if (req[s] == '0) begin
					speed_d[s] = '0;
					rev_d[s]   = 1'b0;
				end else begin
					speed_d[s] = (mag[s] > {1'b0, max_speed_q}) ? max_speed_q
						: mag[s][SPEED_W-1:0];
					rev_d[s]   = req[s][REQ_W-1];
				end
			end
		end
	end

	// Reports use the direction left after any stop in the same tick.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			odo[i] = '0;
		end
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			if (i < 4 && report) begin
				odo[i] = rev_d[i % 2] ? -$signed({1'b0, count_q[i]})
					: $signed({1'b0, count_q[i]});
			end
		end
	end

	always_comb begin
		res.connected      = link_d;
		res.left_setpoint  = speed_d[0];
		res.left_backward  = rev_d[0];
		res.right_setpoint = speed_d[1];
		res.right_backward = rev_d[1];
		res.loop_reset     = stopped;
		res.report_valid   = report;
		res.odometry_a     = odo[0];
		res.odometry_b     = odo[1];
		res.odometry_c     = odo[2];
		res.odometry_d     = odo[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= MAX_SPEED_RST;
			stop_to_q    <= STOP_TO_RST;
			disc_to_q    <= DISC_TO_RST;
			report_per_q <= REPORT_PER_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_SPEED:  max_speed_q  <= cfg_data[SPEED_W-1:0];
				REG_STOP_TO:    stop_to_q    <= cfg_data[TIME_W-1:0];
				REG_DISC_TO:    disc_to_q    <= cfg_data[TIME_W-1:0];
				REG_REPORT_PER: report_per_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= 1'b0;
			since_cmd_q <= '0;
			since_rep_q <= '0;
			for (int s = 0; s < 2; s++) begin
				speed_q[s] <= '0;
				rev_q[s]   <= 1'b0;
			end
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				count_q[i] <= '0;
			end
		end else if (accept) begin
			link_q      <= link_d;
			since_cmd_q <= since_cmd_d;
			since_rep_q <= since_rep_d;
			speed_q     <= speed_d;
			rev_q       <= rev_d;
			count_q     <= count_d;
		end
	end

	// The skid register catches a transaction accepted while the result register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || res_ready) begin
			out_valid_q  <= skid_valid_q | accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || res_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign res_valid      = out_valid_q;
	assign connected      = out_q.connected;
	assign left_setpoint  = out_q.left_setpoint;
	assign left_backward  = out_q.left_backward;
	assign right_setpoint = out_q.right_setpoint;
	assign right_backward = out_q.right_backward;
	assign loop_reset     = out_q.loop_reset;
	assign report_valid   = out_q.report_valid;
	assign odometry_a     = out_q.odometry_a;
	assign odometry_b     = out_q.odometry_b;
	assign odometry_c     = out_q.odometry_c;
	assign odometry_d     = out_q.odometry_d;

endmodule
